FILE: hdl/ght_pkg.sv
// shared constants, codes and types of the generational handle table
package ght_pkg;

  localparam int DEF_ENTRIES      = 4096;
  localparam int DEF_COUNTER_BITS = 15;
  localparam int DEF_TYPE_BITS    = 5;
  localparam int VALUE_W          = 32;
  localparam int OP_W             = 3;
  localparam int STATUS_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_GET    = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HANDLE = 2'd1,
    ST_FULL       = 2'd2
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_e;

  // decision of one operation
  typedef struct packed {
    logic    mem_we;
    status_e status;
  } ght_ctl_t;

endpackage

FILE: hdl/ght_slot_mem.sv
// slot memory: one write port, one read port with registered read data
module ght_slot_mem #(
  parameter int DEPTH = ght_pkg::DEF_ENTRIES,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 60
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          we_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/ght_exec.sv
// operation datapath: checks the handle, builds the write-back word and the result
module ght_exec #(
  parameter int ENTRIES      = ght_pkg::DEF_ENTRIES,
  parameter int COUNTER_BITS = ght_pkg::DEF_COUNTER_BITS,
  parameter int TYPE_BITS    = ght_pkg::DEF_TYPE_BITS,
  parameter int IW           = $clog2(ENTRIES),
  parameter int CW           = $clog2(ENTRIES + 1)
) (
  input  logic [ght_pkg::OP_W-1:0]    op_i,
  input  logic [IW-1:0]               idx_i,
  input  logic [COUNTER_BITS-1:0]     ctr_i,
  input  logic [TYPE_BITS-1:0]        typ_i,
  input  logic [ght_pkg::VALUE_W-1:0] val_i,
  input  logic [IW-1:0]               addr_i,
  // raw slot read
  input  logic [COUNTER_BITS-1:0]     rd_gen_i,
  input  logic                        rd_active_i,
  input  logic [IW-1:0]               rd_next_i,
  input  logic [ght_pkg::VALUE_W-1:0] rd_value_i,
  // table registers
  input  logic [IW-1:0]               head_i,
  input  logic [CW-1:0]               fresh_i,
  input  logic [CW-1:0]               live_i,
  output logic [IW-1:0]               head_o,
  output logic [CW-1:0]               fresh_o,
  output logic [CW-1:0]               live_o,
  // write-back word
  output ght_pkg::ght_ctl_t           ctl_o,
  output logic [COUNTER_BITS-1:0]     wr_gen_o,
  output logic                        wr_active_o,
  output logic [IW-1:0]               wr_next_o,
  output logic [ght_pkg::VALUE_W-1:0] wr_value_o,
  // result
  output logic [IW-1:0]               new_index_o,
  output logic [COUNTER_BITS-1:0]     new_counter_o,
  output logic [TYPE_BITS-1:0]        new_type_o,
  output logic [ght_pkg::VALUE_W-1:0] value_out_o
);

  logic [CW-1:0]           addr_ext;
  logic                    fresh;
  logic [IW-1:0]           fresh_next;
  logic [COUNTER_BITS-1:0] eff_gen;
  logic                    eff_active;
  logic [IW-1:0]           eff_next;
  logic                    in_range;
  logic                    hit;
  logic [COUNTER_BITS-1:0] gen_inc;

  // slots at or above the fresh mark are untouched since clear
  assign addr_ext   = CW'(addr_i);
  assign fresh      = (addr_ext >= fresh_i);
  assign fresh_next = (addr_ext == CW'(ENTRIES - 1)) ? '0 : IW'(addr_ext + CW'(1));
  assign eff_gen    = fresh ? COUNTER_BITS'(1) : rd_gen_i;
  assign eff_active = fresh ? 1'b0 : rd_active_i;
  assign eff_next   = fresh ? fresh_next : rd_next_i;
  assign in_range   = (CW'(idx_i) < CW'(ENTRIES));
  assign hit        = in_range && eff_active && (eff_gen == ctr_i);
  assign gen_inc    = eff_gen + COUNTER_BITS'(1);

  always_comb begin
    head_o        = head_i;
    fresh_o       = fresh_i;
    live_o        = live_i;
    ctl_o.mem_we  = 1'b0;
    ctl_o.status  = ght_pkg::ST_OK;
    wr_gen_o      = eff_gen;
    wr_active_o   = eff_active;
    wr_next_o     = eff_next;
    wr_value_o    = rd_value_i;
    new_index_o   = '0;
    new_counter_o = '0;
    new_type_o    = '0;
    value_out_o   = '0;
    case (ght_pkg::opcode_e'(op_i))
      ght_pkg::OP_ADD: begin
        if (live_i == CW'(ENTRIES)) begin
          ctl_o.status = ght_pkg::ST_FULL;
        end else begin
          ctl_o.mem_we  = 1'b1;
          wr_gen_o      = gen_inc;
          wr_active_o   = 1'b1;
          wr_next_o     = '0;
          wr_value_o    = val_i;
          head_o        = eff_next;
          live_o        = live_i + CW'(1);
          if (fresh) begin
            fresh_o = fresh_i + CW'(1);
          end
          new_index_o   = addr_i;
          new_counter_o = gen_inc;
          new_type_o    = typ_i;
        end
      end
      ght_pkg::OP_REMOVE: begin
        if (hit) begin
          ctl_o.mem_we = 1'b1;
          wr_active_o  = 1'b0;
          wr_next_o    = head_i;
          head_o       = idx_i;
          live_o       = live_i - CW'(1);
        end else begin
          ctl_o.status = ght_pkg::ST_BAD_HANDLE;
        end
      end
      ght_pkg::OP_UPDATE: begin
        if (hit) begin
          ctl_o.mem_we = 1'b1;
          wr_value_o   = val_i;
        end else begin
          ctl_o.status = ght_pkg::ST_BAD_HANDLE;
        end
      end
      ght_pkg::OP_GET: begin
        if (hit) begin
          value_out_o = rd_value_i;
        end else begin
          ctl_o.status = ght_pkg::ST_BAD_HANDLE;
          value_out_o  = '1;
        end
      end
      ght_pkg::OP_CLEAR: begin
        head_o  = '0;
        fresh_o = '0;
        live_o  = '0;
      end
      default: begin
        ctl_o.status = ght_pkg::ST_BAD_HANDLE;
      end
    endcase
  end

endmodule

FILE: hdl/generational_handle_table.sv
// generational handle table: slot map with free list and per-slot generation counters
// the input beat is registered with its slot read; the result beat is registered on commit
// operations run one at a time, each by the read then write-back of one slot
// in the single-port-pair slot memory; a result beat held downstream stalls the write-back
// reset: clears the control registers only; the memory needs no clearing pass since a
// fresh mark shows each slot at or above it as generation 1, inactive, linked to i+1 mod N
module generational_handle_table #(
  parameter int ENTRIES      = ght_pkg::DEF_ENTRIES,
  parameter int COUNTER_BITS = ght_pkg::DEF_COUNTER_BITS,
  parameter int TYPE_BITS    = ght_pkg::DEF_TYPE_BITS,
  parameter int IW           = $clog2(ENTRIES),
  parameter int CW           = $clog2(ENTRIES + 1),
  parameter int IN_W         = IW + COUNTER_BITS + TYPE_BITS + ght_pkg::VALUE_W,
  parameter int IN_PAD       = ((IN_W + 7) / 8) * 8,
  parameter int OUT_W        = IW + COUNTER_BITS + TYPE_BITS + ght_pkg::VALUE_W + CW,
  parameter int OUT_PAD      = ((OUT_W + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // handle_index, handle_counter, handle_type, entry_value_in
  input  logic [IN_PAD-1:0]            s_axis_tdata,
  // opcode
  input  logic [ght_pkg::OP_W-1:0]     s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // new_index, new_counter, new_type, value_out, active_count
  output logic [OUT_PAD-1:0]           m_axis_tdata,
  // status
  output logic [ght_pkg::STATUS_W-1:0] m_axis_tuser
);

  localparam int VW     = ght_pkg::VALUE_W;
  localparam int WORD_W = COUNTER_BITS + 1 + IW + VW;

  // input beat fields
  logic [IW-1:0]           in_idx;
  logic [COUNTER_BITS-1:0] in_ctr;
  logic [TYPE_BITS-1:0]    in_typ;
  logic [VW-1:0]           in_val;
  logic                    in_range;

  // operation held during execution
  logic [ght_pkg::OP_W-1:0] op_q;
  logic [IW-1:0]            idx_q;
  logic [COUNTER_BITS-1:0]  ctr_q;
  logic [TYPE_BITS-1:0]     typ_q;
  logic [VW-1:0]            val_q;
  logic [IW-1:0]            addr_q;
  logic [IW-1:0]            rd_addr;

  // table registers: free-list head, fresh mark, active count
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] fresh_q, fresh_d;
  logic [CW-1:0] live_q, live_d;

  // control
  ght_pkg::fsm_e     state_q, state_d;
  logic              accept;
  logic              commit;
  ght_pkg::ght_ctl_t ctl;

  // slot memory word: generation, active, next free link, value
  logic [WORD_W-1:0]       rd_word;
  logic [WORD_W-1:0]       wr_word;
  logic [COUNTER_BITS-1:0] wr_gen;
  logic                    wr_active;
  logic [IW-1:0]           wr_next;
  logic [VW-1:0]           wr_value;

  // result
  logic [IW-1:0]           res_idx;
  logic [COUNTER_BITS-1:0] res_ctr;
  logic [TYPE_BITS-1:0]    res_typ;
  logic [VW-1:0]           res_val;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [OUT_W-1:0]              out_data_q;
  logic [ght_pkg::STATUS_W-1:0]  out_status_q;

  assign in_idx = s_axis_tdata[IW-1:0];
  assign in_ctr = s_axis_tdata[IW +: COUNTER_BITS];
  assign in_typ = s_axis_tdata[IW + COUNTER_BITS +: TYPE_BITS];
  assign in_val = s_axis_tdata[IW + COUNTER_BITS + TYPE_BITS +: VW];

  // add reads the free-list head, the rest read the handle's slot
  assign in_range = (CW'(in_idx) < CW'(ENTRIES));
  assign rd_addr  = (ght_pkg::opcode_e'(s_axis_tuser) == ght_pkg::OP_ADD) ? head_q :
                    (in_range ? in_idx : '0);

  // two-state sequencer: read the slot, then modify and write it back
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    accept        = 1'b0;
    commit        = 1'b0;
    out_valid_d   = out_valid_q && !m_axis_tready;
    case (state_q)
      ght_pkg::FSM_IDLE: begin
        // takes a beat even while a finished result still waits downstream
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          accept  = 1'b1;
          state_d = ght_pkg::FSM_EXEC;
        end
      end
      ght_pkg::FSM_EXEC: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          commit      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ght_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = ght_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ght_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      fresh_q     <= '0;
      live_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        head_q  <= head_d;
        fresh_q <= fresh_d;
        live_q  <= live_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      idx_q  <= in_idx;
      ctr_q  <= in_ctr;
      typ_q  <= in_typ;
      val_q  <= in_val;
      addr_q <= rd_addr;
    end
    if (commit) begin
      out_data_q   <= {live_d, res_val, res_typ, res_ctr, res_idx};
      out_status_q <= ctl.status;
    end
  end

  assign wr_word = {wr_gen, wr_active, wr_next, wr_value};

  ght_slot_mem #(
    .DEPTH (ENTRIES),
    .AW    (IW),
    .DW    (WORD_W)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_word),
    .we_i      (commit && ctl.mem_we),
    .wr_addr_i (addr_q),
    .wr_data_i (wr_word)
  );

  ght_exec #(
    .ENTRIES      (ENTRIES),
    .COUNTER_BITS (COUNTER_BITS),
    .TYPE_BITS    (TYPE_BITS),
    .IW           (IW),
    .CW           (CW)
  ) u_exec (
    .op_i          (op_q),
    .idx_i         (idx_q),
    .ctr_i         (ctr_q),
    .typ_i         (typ_q),
    .val_i         (val_q),
    .addr_i        (addr_q),
    .rd_gen_i      (rd_word[WORD_W-1 -: COUNTER_BITS]),
    .rd_active_i   (rd_word[IW + VW]),
    .rd_next_i     (rd_word[VW +: IW]),
    .rd_value_i    (rd_word[VW-1:0]),
    .head_i        (head_q),
    .fresh_i       (fresh_q),
    .live_i        (live_q),
    .head_o        (head_d),
    .fresh_o       (fresh_d),
    .live_o        (live_d),
    .ctl_o         (ctl),
    .wr_gen_o      (wr_gen),
    .wr_active_o   (wr_active),
    .wr_next_o     (wr_next),
    .wr_value_o    (wr_value),
    .new_index_o   (res_idx),
    .new_counter_o (res_ctr),
    .new_type_o    (res_typ),
    .value_out_o   (res_val)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_PAD'(out_data_q);
  assign m_axis_tuser  = out_status_q;

endmodule

FILE: verif/tb_generational_handle_table.sv
// testbench of the generational handle table: directed table and random mix
module tb_generational_handle_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ght_pkg::*;

  // widths as the block builds them with its default parameters
  localparam int ENTRIES     = DEF_ENTRIES;
  localparam int GW          = DEF_COUNTER_BITS;
  localparam int TW          = DEF_TYPE_BITS;
  localparam int IW          = $clog2(ENTRIES);
  localparam int CW          = $clog2(ENTRIES + 1);
  localparam int IN_PAD      = ((IW + GW + TW + VALUE_W + 7) / 8) * 8;
  localparam int OUT_W       = IW + GW + TW + VALUE_W + CW;
  localparam int OUT_PAD     = ((OUT_W + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 1000;  // cycles with no beat on either side
  localparam int MAX_SHOWN   = 10;
  localparam int HOLD_CAP    = 48;    // live handles kept by the random mix
  localparam int GONE_CAP    = 32;    // removed handles kept for stale accesses
  localparam int MIX_ITEMS   = 1420;
  localparam int CALM_ITEMS  = 150;   // closing stretch of the mix without idling

  // one request beat
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] val;
    logic [TW-1:0]      typ;
    logic [GW-1:0]      ctr;
    logic [IW-1:0]      idx;
  } cmd_t;

  // one result beat, laid out as {tuser, tdata} so it packs straight from the ports
  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [CW-1:0]       cnt;
    logic [VALUE_W-1:0]  vout;
    logic [TW-1:0]       ntyp;
    logic [GW-1:0]       nctr;
    logic [IW-1:0]       nidx;
  } resp_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [GW-1:0] ctr;
  } handle_t;

  typedef struct {
    cmd_t  c;
    bit    typed;
    resp_t r;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // handle_index, handle_counter, handle_type, entry_value_in
  logic [IN_PAD-1:0]   s_axis_tdata;
  // opcode
  logic [OP_W-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // new_index, new_counter, new_type, value_out, active_count
  logic [OUT_PAD-1:0]  m_axis_tdata;
  // status
  logic [STATUS_W-1:0] m_axis_tuser;

  // shadow copy of the slot table
  logic [VALUE_W-1:0] tbl_val  [ENTRIES];
  logic [GW-1:0]      tbl_gen  [ENTRIES];
  bit                 tbl_live [ENTRIES];
  logic [IW-1:0]      tbl_link [ENTRIES];
  logic [IW-1:0]      free_top;
  int unsigned        live_slots;

  resp_t    pending_q[$];   // results still owed by the block, oldest first
  handle_t  held_q[$];      // handles known to be live
  handle_t  gone_q[$];      // handles removed a while ago
  dir_row_t dir_rows[$];

  bit    idle_on;
  int    stall_left;
  int    quiet_cycles;
  int    err_cnt;
  resp_t seen_r;
  resp_t want_r;

  generational_handle_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // free list back to 0..N-1, every generation back to 1
  function automatic void wipe_table();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_val[i]  = '0;
      tbl_gen[i]  = GW'(1);
      tbl_live[i] = 1'b0;
      tbl_link[i] = IW'(i + 1);
    end
    free_top   = '0;
    live_slots = 0;
  endfunction

  // runs one operation on the shadow table and returns the result it must produce
  function automatic resp_t apply_op(cmd_t c);
    resp_t         r;
    logic [IW-1:0] s;
    bit            hit;
    r   = '0;
    // every index that fits the field is inside the table
    hit = tbl_live[c.idx] && (tbl_gen[c.idx] == c.ctr);
    case (c.op)
      OP_ADD: begin
        if (live_slots >= ENTRIES) begin
          r.st = ST_FULL;
        end else begin
          s           = free_top;
          free_top    = tbl_link[s];
          tbl_link[s] = '0;
          tbl_gen[s]  = tbl_gen[s] + 1'b1;  // wraps through zero
          tbl_live[s] = 1'b1;
          tbl_val[s]  = c.val;
          live_slots++;
          r.nidx = s;
          r.nctr = tbl_gen[s];
          r.ntyp = c.typ;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          tbl_link[c.idx] = free_top;
          free_top        = c.idx;
          tbl_live[c.idx] = 1'b0;
          live_slots--;
        end else begin
          r.st = ST_BAD_HANDLE;
        end
      end
      OP_UPDATE: begin
        if (hit) tbl_val[c.idx] = c.val;
        else r.st = ST_BAD_HANDLE;
      end
      OP_GET: begin
        if (hit) begin
          r.vout = tbl_val[c.idx];
        end else begin
          r.st   = ST_BAD_HANDLE;
          r.vout = '1;
        end
      end
      OP_CLEAR: wipe_table();
      default: r.st = ST_BAD_HANDLE;  // opcodes past clear
    endcase
    r.cnt = CW'(live_slots);
    return r;
  endfunction

  function automatic cmd_t mk(logic [OP_W-1:0] op, int unsigned idx, int unsigned ctr,
                              int unsigned typ, logic [VALUE_W-1:0] val);
    cmd_t c;
    c.op  = op;
    c.idx = IW'(idx);
    c.ctr = GW'(ctr);
    c.typ = TW'(typ);
    c.val = val;
    return c;
  endfunction

  // one line of the directed table; typed rows carry the result read off by hand
  function automatic void row(bit typed, logic [OP_W-1:0] op, int unsigned idx,
                              int unsigned ctr, int unsigned typ, logic [VALUE_W-1:0] val,
                              logic [STATUS_W-1:0] st, int unsigned nidx, int unsigned nctr,
                              int unsigned ntyp, logic [VALUE_W-1:0] vout, int unsigned cnt);
    dir_row_t d;
    d.c      = mk(op, idx, ctr, typ, val);
    d.typed  = typed;
    d.r.st   = st;
    d.r.nidx = IW'(nidx);
    d.r.nctr = GW'(nctr);
    d.r.ntyp = TW'(ntyp);
    d.r.vout = vout;
    d.r.cnt  = CW'(cnt);
    dir_rows.push_back(d);
  endfunction

  // drives one request beat from a falling edge, waits for it to be taken, logs what it owes
  task automatic send(cmd_t c, bit typed, resp_t fixed);
    resp_t r;
    int    gap;
    int    k;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_PAD'({c.val, c.typ, c.ctr, c.idx});
    s_axis_tuser  <= c.op;
    do @(posedge clk_i); while (!s_axis_tready);
    r = apply_op(c);
    pending_q.push_back(typed ? fixed : r);
    // keep the handle lists in step with the table
    if (c.op == OP_ADD && r.st == ST_OK) begin
      held_q.push_back({r.nidx, r.nctr});
    end else if (c.op == OP_REMOVE && r.st == ST_OK) begin
      for (k = 0; k < held_q.size(); k++) begin
        if (held_q[k].idx == c.idx) begin
          held_q.delete(k);
          break;
        end
      end
      gone_q.push_back({c.idx, c.ctr});
      if (gone_q.size() > GONE_CAP) void'(gone_q.pop_front());
    end else if (c.op == OP_CLEAR) begin
      held_q.delete();
    end
    @(negedge clk_i);
  endtask

  // result side: ready drops in bursts while idling is on
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 17);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker and watchdog
  initial begin
    quiet_cycles = 0;
    err_cnt      = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_r = {m_axis_tuser, m_axis_tdata[OUT_W-1:0]};
        if (pending_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display({"result beat with nothing pending: ",
                      "st=%0d idx=%0d ctr=%0d typ=%0d val=%h cnt=%0d"},
                     seen_r.st, seen_r.nidx, seen_r.nctr, seen_r.ntyp, seen_r.vout,
                     seen_r.cnt);
        end else begin
          want_r = pending_q.pop_front();
          if (seen_r !== want_r) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN) begin
              $display("mismatch at %0t: expected st=%0d idx=%0d ctr=%0d typ=%0d val=%h cnt=%0d",
                       $realtime, want_r.st, want_r.nidx, want_r.nctr, want_r.ntyp, want_r.vout,
                       want_r.cnt);
              $display("                 got      st=%0d idx=%0d ctr=%0d typ=%0d val=%h cnt=%0d",
                       seen_r.st, seen_r.nidx, seen_r.nctr, seen_r.ntyp, seen_r.vout, seen_r.cnt);
            end
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    cmd_t    c;
    handle_t h;
    resp_t   no_fix;
    int      pick;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    idle_on       = 1'b1;
    no_fix        = '0;
    wipe_table();

    // directed table: fresh table after reset, extreme fields, every opcode, stale handles
    row(1, OP_GET,    0,    1,     0,  32'h0,         ST_BAD_HANDLE, 0, 0, 0,  32'hFFFF_FFFF, 0);
    row(1, OP_ADD,    4095, 32767, 31, 32'h7FFF_FFFF, ST_OK,         0, 2, 31, 32'h0,         1);
    row(1, OP_ADD,    0,    0,     0,  32'h8000_0000, ST_OK,         1, 2, 0,  32'h0,         2);
    row(1, OP_GET,    0,    2,     31, 32'h0,         ST_OK,         0, 0, 0,  32'h7FFF_FFFF, 2);
    row(1, OP_GET,    1,    2,     0,  32'h0,         ST_OK,         0, 0, 0,  32'h8000_0000, 2);
    row(1, OP_UPDATE, 1,    2,     0,  32'hFFFF_FFFF, ST_OK,         0, 0, 0,  32'h0,         2);
    row(0, OP_GET,    1,    2,     0,  32'h0,         ST_OK,         0, 0, 0,  32'h0,         0);
    // stale generation on an active slot
    row(1, OP_GET,    1,    1,     0,  32'h0,         ST_BAD_HANDLE, 0, 0, 0,  32'hFFFF_FFFF, 2);
    row(1, OP_UPDATE, 0,    3,     0,  32'h1234_5678, ST_BAD_HANDLE, 0, 0, 0,  32'h0,         2);
    row(1, OP_REMOVE, 0,    2,     0,  32'h0,         ST_OK,         0, 0, 0,  32'h0,         1);
    // slot no longer active
    row(1, OP_REMOVE, 0,    2,     0,  32'h0,         ST_BAD_HANDLE, 0, 0, 0,  32'h0,         1);
    row(0, OP_GET,    0,    2,     0,  32'h0,         ST_OK,         0, 0, 0,  32'h0,         0);
    // removed slot comes back from the head of the free list
    row(1, OP_ADD,    0,    0,     5,  32'd123,       ST_OK,         0, 3, 5,  32'h0,         2);
    row(1, OP_GET,    4095, 32767, 31, 32'hFFFF_FFFF, ST_BAD_HANDLE, 0, 0, 0,  32'hFFFF_FFFF, 2);
    row(1, OP_REMOVE, 4095, 1,     0,  32'h0,         ST_BAD_HANDLE, 0, 0, 0,  32'h0,         2);
    // opcodes above clear are rejected
    for (int k = int'(OP_CLEAR) + 1; k < 2 ** OP_W; k++)
      row(1, OP_W'(k), 4095, 32767, 31, 32'hFFFF_FFFF, ST_BAD_HANDLE, 0, 0, 0, 32'h0, 2);
    row(0, OP_UPDATE, 2,    1,     0,  32'h5555_AAAA, ST_OK,         0, 0, 0,  32'h0,         0);
    row(0, OP_GET,    1,    2,     0,  32'h0,         ST_OK,         0, 0, 0,  32'h0,         0);
    row(1, OP_CLEAR,  4095, 32767, 31, 32'hFFFF_FFFF, ST_OK,         0, 0, 0,  32'h0,         0);
    row(1, OP_GET,    0,    3,     0,  32'h0,         ST_BAD_HANDLE, 0, 0, 0,  32'hFFFF_FFFF, 0);
    row(1, OP_ADD,    0,    0,     31, 32'h0,         ST_OK,         0, 2, 31, 32'h0,         1);
    row(0, OP_ADD,    0,    0,     10, 32'hDEAD_BEEF, ST_OK,         0, 0, 0,  32'h0,         0);
    row(0, OP_REMOVE, 0,    2,     0,  32'h0,         ST_OK,         0, 0, 0,  32'h0,         0);
    row(0, OP_ADD,    0,    0,     21, 32'h0F0F_0F0F, ST_OK,         0, 0, 0,  32'h0,         0);
    row(0, OP_GET,    0,    3,     0,  32'h0,         ST_OK,         0, 0, 0,  32'h0,         0);

    // reset held low from the start, released on a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);

    // random mix: mostly valid handles, the rest stale, removed, random or bad opcodes
    for (int n = 0; n < MIX_ITEMS; n++) begin
      // every third stretch and the closing stretch run without idling
      idle_on = (n < MIX_ITEMS - CALM_ITEMS) && (((n / 150) % 3) != 2);
      pick = $urandom_range(0, 99);
      c    = mk(OP_ADD, $urandom, $urandom, $urandom, $urandom);
      if (held_q.size() == 0 && pick >= 28 && pick < 84) pick = 0;
      if (held_q.size() >= HOLD_CAP && pick < 28) pick = 30;
      if (pick < 28) begin
        c.op = OP_ADD;
      end else if (pick < 84) begin
        h     = held_q[$urandom_range(0, held_q.size() - 1)];
        c.idx = h.idx;
        c.ctr = h.ctr;
        if (pick < 46) begin
          c.op = OP_REMOVE;
        end else if (pick < 62) begin
          c.op = OP_UPDATE;
        end else if (pick < 78) begin
          c.op = OP_GET;
        end else begin
          // live slot, wrong generation
          c.op  = OP_W'($urandom_range(int'(OP_REMOVE), int'(OP_GET)));
          c.ctr = h.ctr + GW'($urandom_range(1, 2 ** GW - 1));
        end
      end else if (pick < 89 && gone_q.size() != 0) begin
        h     = gone_q[$urandom_range(0, gone_q.size() - 1)];
        c.idx = h.idx;
        c.ctr = h.ctr;
        c.op  = OP_W'($urandom_range(int'(OP_REMOVE), int'(OP_GET)));
      end else if (pick < 95) begin
        c.op = OP_W'($urandom_range(int'(OP_REMOVE), int'(OP_GET)));
      end else if (pick < 98) begin
        c.op = OP_W'($urandom_range(int'(OP_CLEAR) + 1, 2 ** OP_W - 1));
      end else begin
        c.op = OP_CLEAR;
      end
      send(c, 1'b0, no_fix);
    end

    s_axis_tvalid <= 1'b0;
    // drain, then wait on to catch a stray result beat
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: generational_handle_table.f
hdl/ght_pkg.sv
hdl/ght_slot_mem.sv
hdl/ght_exec.sv
hdl/generational_handle_table.sv
verif/tb_generational_handle_table.sv
